[rtl/pidv_pkg.sv]
// Shared types, widths and constants for the variable-timestep PID controller.
package pidv_pkg;

   localparam int ACC_WIDTH_DEF = 48;

   localparam int ERR_W   = 17;   // setpoint minus position
   localparam int DIFF_W  = 18;   // error minus last error
   localparam int DT_W    = 16;   // elapsed microseconds
   localparam int CFG_W   = 16;   // widest config register
   localparam int DRIVE_W = 32;

   // shared multiplier operand and product widths
   localparam int MUL_A_W = 18;
   localparam int MUL_B_W = 25;
   localparam int MUL_P_W = MUL_A_W + MUL_B_W;

   localparam int DNUM_W  = 33;   // magnitude of the derivative numerator
   localparam int SUM_W   = 50;   // P + I + D before rescale
   localparam int IVAL_W  = 64;   // integral product
   localparam int ILIM_BIT = 46;  // integral term clip at +-2^46
   localparam int ILO_W   = 24;   // low slice of accumulator per multiply pass
   localparam int FRAC_W  = 8;    // Q8.8 rescale

   localparam logic signed [IVAL_W-1:0] ITERM_LIM = 64'sh0000_4000_0000_0000;
   localparam logic signed [SUM_W-1:0]  DRIVE_MAX = SUM_W'(2147483647);
   localparam logic signed [SUM_W-1:0]  DRIVE_MIN = -DRIVE_MAX - SUM_W'(1);

   // config register indexes
   localparam logic [1:0] CSR_SETPOINT = 2'd0;
   localparam logic [1:0] CSR_GAIN_P   = 2'd1;
   localparam logic [1:0] CSR_GAIN_I   = 2'd2;
   localparam logic [1:0] CSR_GAIN_D   = 2'd3;

   localparam logic REQ_SAMPLE = 1'b0;
   localparam logic REQ_CLEAR  = 1'b1;

   typedef enum logic [3:0] {
      S_IDLE,
      S_DELTA,
      S_ACC,
      S_PTERM,
      S_DNUM,
      S_ILO,
      S_IHI,
      S_ICLIP,
      S_IADD,
      S_DWAIT,
      S_FIN,
      S_WRITE
   } state_type;

endpackage

[rtl/pidv_mul.sv]
// Shared signed multiplier with registered product.
module pidv_mul (
   input  logic                                 clock,
   input  logic signed [pidv_pkg::MUL_A_W-1:0]  mul_a,
   input  logic signed [pidv_pkg::MUL_B_W-1:0]  mul_b,
   output logic signed [pidv_pkg::MUL_P_W-1:0]  prod_ff
);
   import pidv_pkg::*;

   logic signed [MUL_P_W-1:0] prod_in;

   assign prod_in = MUL_P_W'(mul_a) * MUL_P_W'(mul_b);

   always_ff @(posedge clock) begin
      prod_ff <= prod_in;
   end

endmodule

[rtl/pidv_div.sv]
// Radix-2 restoring divider, one quotient bit per cycle, unsigned.
module pidv_div (
   input  logic                           clock,
   input  logic                           reset,
   input  logic                           start,
   input  logic [pidv_pkg::DNUM_W-1:0]    num,
   input  logic [pidv_pkg::DT_W-1:0]      den,
   output logic                           done,
   output logic [pidv_pkg::DNUM_W-1:0]    quot
);
   import pidv_pkg::*;

   localparam int CNT_W = $clog2(DNUM_W + 1);

   logic              busy_ff, busy_in;
   logic              done_ff, done_in;
   logic [CNT_W-1:0]  cnt_ff, cnt_in;
   logic [DT_W-1:0]   rem_ff, rem_in;
   logic [DNUM_W-1:0] quo_ff, quo_in;
   logic [DT_W-1:0]   den_ff, den_in;

   logic [DT_W:0] trial;
   logic [DT_W:0] diff;
   logic          ge;

   always_comb begin
      trial = {rem_ff, quo_ff[DNUM_W-1]};
      diff  = trial - {1'b0, den_ff};
      ge    = (trial >= {1'b0, den_ff});

      busy_in = busy_ff;
      done_in = done_ff;
      cnt_in  = cnt_ff;
      rem_in  = rem_ff;
      quo_in  = quo_ff;
      den_in  = den_ff;

      if (start) begin
         busy_in = 1'b1;
         done_in = 1'b0;
         cnt_in  = '0;
         rem_in  = '0;
         quo_in  = num;
         den_in  = den;
      end else if (busy_ff) begin
         rem_in = ge ? diff[DT_W-1:0] : trial[DT_W-1:0];
         quo_in = {quo_ff[DNUM_W-2:0], ge};
         cnt_in = cnt_ff + CNT_W'(1);
         if (cnt_ff == CNT_W'(DNUM_W - 1)) begin
            busy_in = 1'b0;
            done_in = 1'b1;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         busy_ff <= 1'b0;
         done_ff <= 1'b0;
         cnt_ff  <= '0;
      end else begin
         busy_ff <= busy_in;
         done_ff <= done_in;
         cnt_ff  <= cnt_in;
      end
      rem_ff <= rem_in;
      quo_ff <= quo_in;
      den_ff <= den_in;
   end

   assign done = done_ff;
   assign quot = quo_ff;

endmodule

[rtl/pid_controller_variable_dt.sv]
// Top level of the variable-timestep PID controller: sequencer, state and stream ports.
//
// Fixed-point PID loop with a variable time step. Each request transfer carries a measured
// position and the microseconds since the previous sample (0 counts as 1); the block forms
// err = setpoint - position, integrates err*dt into a saturating ACC_WIDTH-bit accumulator,
// and returns floor((Kp*err + Ki*acc + Kd*(err - last_err)/dt) / 256) clipped to 32 bits,
// with a flag set when either the accumulator or the drive clipped. A clear request zeroes
// the accumulator and the last error and returns zero. One request is in flight at a time:
// a sample holds the block from its request transfer until the sequencer is back in idle.
// The multiplier passes for err*dt, P and the D numerator run before the divider starts,
// the one-bit-per-cycle divider then forms the derivative term, and the sequencer finally
// folds in the quotient, rescales and loads the output register; the two integral passes run
// under the divider, for five passes through the single shared 18x25 multiplier in all.
// A clear request goes straight to loading the output register and then back to idle.
// The result sits in an output register, so the next request is taken as soon as the
// sequencer is back in idle, even if the result has not yet been transferred; while that
// register still holds an untaken result the sequencer waits before loading it.
// Gains are signed Q8.8; config writes go through the csr port and are intended only while
// the block is idle.
module pid_controller_variable_dt #(
   parameter int ACC_WIDTH = pidv_pkg::ACC_WIDTH_DEF
) (
   input  logic        clock,
   input  logic        reset,

   input  logic        req_tvalid,
   output logic        req_tready,
   input  logic [31:0] req_tdata,   // [15:0] position, [31:16] elapsed_us
   input  logic [0:0]  req_tuser,   // [0] req_type: 0 sample, 1 clear

   output logic        rsp_tvalid,
   input  logic        rsp_tready,
   output logic [31:0] rsp_tdata,   // [31:0] drive
   output logic [0:0]  rsp_tuser,   // [0] saturated

   input  logic        csr_we,
   input  logic [1:0]  csr_index,
   input  logic [pidv_pkg::CFG_W-1:0] csr_wdata
);
   import pidv_pkg::*;

   // config registers
   logic signed [CFG_W-1:0] setpoint_ff, gain_p_ff, gain_i_ff, gain_d_ff;

   // loop state
   state_type                   state_ff, state_in;
   logic signed [ACC_WIDTH-1:0] acc_ff, acc_in;
   logic signed [ERR_W-1:0]     prev_ff, prev_in;

   // per-sample working registers
   logic signed [ERR_W-1:0]   err_ff, err_in;
   logic [DT_W-1:0]           dt_ff, dt_in;
   logic                      sat_ff, sat_in;
   logic signed [SUM_W-1:0]   sum_ff, sum_in;
   logic signed [IVAL_W-1:0]  ival_ff, ival_in;
   logic                      dneg_ff, dneg_in;
   logic [DRIVE_W-1:0]        drive_ff, drive_in;

   // output register
   logic               rsp_valid_ff, rsp_valid_in;
   logic [DRIVE_W-1:0] rsp_drive_ff, rsp_drive_in;
   logic               rsp_sat_ff, rsp_sat_in;

   // shared multiplier and divider hookup
   logic signed [MUL_A_W-1:0] mul_a;
   logic signed [MUL_B_W-1:0] mul_b;
   logic signed [MUL_P_W-1:0] prod_ff;
   logic                      div_start;
   logic [DNUM_W-1:0]         div_num;
   logic                      div_done;
   logic [DNUM_W-1:0]         div_quot;

   // combinational helpers
   logic signed [ACC_WIDTH:0]   acc_sum;
   logic signed [IVAL_W-1:0]    acc_ext;
   logic                        acc_big;
   logic signed [DIFF_W-1:0]    err_diff;
   logic signed [DNUM_W:0]      dnum;
   logic signed [SUM_W-1:0]     dquot;
   logic signed [SUM_W-1:0]     scaled;

   localparam logic signed [ACC_WIDTH-1:0] ACC_MAX = {1'b0, {(ACC_WIDTH-1){1'b1}}};
   localparam logic signed [ACC_WIDTH-1:0] ACC_MIN = {1'b1, {(ACC_WIDTH-1){1'b0}}};

   pidv_mul u_mul (
      .clock   (clock),
      .mul_a   (mul_a),
      .mul_b   (mul_b),
      .prod_ff (prod_ff)
   );

   pidv_div u_div (
      .clock (clock),
      .reset (reset),
      .start (div_start),
      .num   (div_num),
      .den   (dt_ff),
      .done  (div_done),
      .quot  (div_quot)
   );

   // config writes; all four index codes select a register, so the default arm is never taken
   always_ff @(posedge clock) begin
      if (reset) begin
         setpoint_ff <= '0;
         gain_p_ff   <= '0;
         gain_i_ff   <= '0;
         gain_d_ff   <= '0;
      end else if (csr_we) begin
         case (csr_index)
            CSR_SETPOINT: setpoint_ff <= csr_wdata;
            CSR_GAIN_P:   gain_p_ff   <= csr_wdata;
            CSR_GAIN_I:   gain_i_ff   <= csr_wdata;
            CSR_GAIN_D:   gain_d_ff   <= csr_wdata;
            default: ;
         endcase
      end
   end

   // accumulator outside [-2^46, 2^46) makes the integral term clip for any nonzero gain
   assign acc_ext  = IVAL_W'(acc_ff);
   assign acc_big  = (acc_ext >= ITERM_LIM) || (acc_ext < -ITERM_LIM);
   assign acc_sum  = (ACC_WIDTH+1)'(acc_ff) + (ACC_WIDTH+1)'($signed(prod_ff[32:0]));
   assign err_diff = DIFF_W'(err_ff) - DIFF_W'(prev_ff);
   assign dnum     = $signed(prod_ff[DNUM_W:0]);
   assign dquot    = SUM_W'($signed({1'b0, div_quot}));
   assign scaled   = sum_ff >>> FRAC_W;   // floor divide by 256

   always_comb begin
      state_in     = state_ff;
      acc_in       = acc_ff;
      prev_in      = prev_ff;
      err_in       = err_ff;
      dt_in        = dt_ff;
      sat_in       = sat_ff;
      sum_in       = sum_ff;
      ival_in      = ival_ff;
      dneg_in      = dneg_ff;
      drive_in     = drive_ff;
      rsp_drive_in = rsp_drive_ff;
      rsp_sat_in   = rsp_sat_ff;
      rsp_valid_in = rsp_valid_ff && !rsp_tready;
      mul_a        = '0;
      mul_b        = '0;
      div_start    = 1'b0;
      div_num      = '0;

      case (state_ff)
         S_IDLE: begin
            if (req_tvalid) begin
               if (req_tuser[0] == REQ_CLEAR) begin
                  acc_in   = '0;
                  prev_in  = '0;
                  drive_in = '0;
                  sat_in   = 1'b0;
                  state_in = S_WRITE;
               end else begin
                  err_in   = ERR_W'(setpoint_ff) - ERR_W'($signed(req_tdata[15:0]));
                  dt_in    = (req_tdata[31:16] == '0) ? DT_W'(1) : req_tdata[31:16];
                  sat_in   = 1'b0;
                  state_in = S_DELTA;
               end
            end
         end

         S_DELTA: begin
            mul_a    = MUL_A_W'(err_ff);
            mul_b    = MUL_B_W'($signed({1'b0, dt_ff}));
            state_in = S_ACC;
         end

         S_ACC: begin
            // product holds err*dt
            if (acc_sum[ACC_WIDTH] != acc_sum[ACC_WIDTH-1]) begin
               acc_in = acc_sum[ACC_WIDTH] ? ACC_MIN : ACC_MAX;
               sat_in = 1'b1;
            end else begin
               acc_in = acc_sum[ACC_WIDTH-1:0];
            end
            mul_a    = MUL_A_W'(gain_p_ff);
            mul_b    = MUL_B_W'(err_ff);
            state_in = S_PTERM;
         end

         S_PTERM: begin
            sum_in   = SUM_W'($signed(prod_ff[32:0]));
            mul_a    = MUL_A_W'(gain_d_ff);
            mul_b    = MUL_B_W'(err_diff);
            prev_in  = err_ff;
            state_in = S_DNUM;
         end

         S_DNUM: begin
            // divide |Kd*(err - last_err)| by dt, sign restored afterwards
            dneg_in   = dnum[DNUM_W];
            div_start = 1'b1;
            div_num   = dnum[DNUM_W] ? DNUM_W'(-dnum) : dnum[DNUM_W-1:0];
            mul_a     = MUL_A_W'(gain_i_ff);
            mul_b     = MUL_B_W'({1'b0, acc_ext[ILO_W-1:0]});
            state_in  = S_ILO;
         end

         S_ILO: begin
            ival_in  = IVAL_W'(prod_ff);
            mul_a    = MUL_A_W'(gain_i_ff);
            mul_b    = MUL_B_W'($signed(acc_ext[ILIM_BIT:ILO_W]));
            state_in = S_IHI;
         end

         S_IHI: begin
            ival_in  = ival_ff + (IVAL_W'(prod_ff) <<< ILO_W);
            state_in = S_ICLIP;
         end

         S_ICLIP: begin
            if (acc_big) begin
               if (gain_i_ff == '0) begin
                  ival_in = '0;
               end else begin
                  ival_in = (gain_i_ff[CFG_W-1] ^ acc_ext[IVAL_W-1]) ? -ITERM_LIM : ITERM_LIM;
               end
            end else if (ival_ff > ITERM_LIM) begin
               ival_in = ITERM_LIM;
            end else if (ival_ff < -ITERM_LIM) begin
               ival_in = -ITERM_LIM;
            end
            state_in = S_IADD;
         end

         S_IADD: begin
            sum_in   = sum_ff + SUM_W'(ival_ff);
            state_in = S_DWAIT;
         end

         S_DWAIT: begin
            if (div_done) begin
               sum_in   = sum_ff + (dneg_ff ? -dquot : dquot);
               state_in = S_FIN;
            end
         end

         S_FIN: begin
            if (scaled > DRIVE_MAX) begin
               drive_in = DRIVE_MAX[DRIVE_W-1:0];
               sat_in   = 1'b1;
            end else if (scaled < DRIVE_MIN) begin
               drive_in = DRIVE_MIN[DRIVE_W-1:0];
               sat_in   = 1'b1;
            end else begin
               drive_in = scaled[DRIVE_W-1:0];
            end
            state_in = S_WRITE;
         end

         S_WRITE: begin
            // hand over once the output register is free or draining this cycle
            if (!rsp_valid_ff || rsp_tready) begin
               rsp_valid_in = 1'b1;
               rsp_drive_in = drive_ff;
               rsp_sat_in   = sat_ff;
               state_in     = S_IDLE;
            end
         end

         default: begin
            state_in = S_IDLE;
         end
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= S_IDLE;
         acc_ff       <= '0;
         prev_ff      <= '0;
         rsp_valid_ff <= 1'b0;
      end else begin
         state_ff     <= state_in;
         acc_ff       <= acc_in;
         prev_ff      <= prev_in;
         rsp_valid_ff <= rsp_valid_in;
      end
      err_ff       <= err_in;
      dt_ff        <= dt_in;
      sat_ff       <= sat_in;
      sum_ff       <= sum_in;
      ival_ff      <= ival_in;
      dneg_ff      <= dneg_in;
      drive_ff     <= drive_in;
      rsp_drive_ff <= rsp_drive_in;
      rsp_sat_ff   <= rsp_sat_in;
   end

   assign req_tready   = (state_ff == S_IDLE);
   assign rsp_tvalid   = rsp_valid_ff;
   assign rsp_tdata    = rsp_drive_ff;
   assign rsp_tuser[0] = rsp_sat_ff;

endmodule
